FILE: sv/e2q_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package e2q_pkg;

	localparam int CORDIC_STEPS      = 30;
	localparam int ANGLE_BITS_DEF    = 16;
	localparam int OUT_FRAC_BITS_DEF = 14;
	localparam int PH_W              = 34;
	localparam int CS_W              = 32;

	typedef logic signed [CS_W-1:0] cs_t;
	typedef logic signed [PH_W-1:0] phase_t;

	localparam cs_t CORDIC_GAIN = 32'sd652032874;

	// atan(2^-i), 2^32 units per turn
	function automatic phase_t atan_step(input int i);
		phase_t r;
		case (i)
			0: r = 34'sd536870912;
			1: r = 34'sd316933406;
			2: r = 34'sd167458907;
			3: r = 34'sd85004756;
			4: r = 34'sd42667331;
			5: r = 34'sd21354465;
			6: r = 34'sd10679838;
			7: r = 34'sd5340245;
			8: r = 34'sd2670163;
			9: r = 34'sd1335087;
			10: r = 34'sd667544;
			11: r = 34'sd333772;
			12: r = 34'sd166886;
			13: r = 34'sd83443;
			14: r = 34'sd41722;
			15: r = 34'sd20861;
			16: r = 34'sd10430;
			17: r = 34'sd5215;
			18: r = 34'sd2608;
			19: r = 34'sd1304;
			20: r = 34'sd652;
			21: r = 34'sd326;
			22: r = 34'sd163;
			23: r = 34'sd81;
			24: r = 34'sd41;
			25: r = 34'sd20;
			26: r = 34'sd10;
			27: r = 34'sd5;
			28: r = 34'sd3;
			29: r = 34'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Q2.30 product, rounded half up
	function automatic cs_t mul30(input cs_t a, input cs_t b);
		logic signed [2*CS_W-1:0] p;
		p = (64'(a) * 64'(b)) + 64'sd536870912;
		return p[61:30];
	endfunction

endpackage
`default_nettype wire

FILE: sv/e2q_angle_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface e2q_angle_if #(parameter int W = 16);
	logic         valid;
	logic         ready;
	logic [W-1:0] angle_first;
	logic [W-1:0] angle_second;
	logic [W-1:0] angle_third;
	modport source (output valid, angle_first, angle_second, angle_third, input ready);
	modport sink (input valid, angle_first, angle_second, angle_third, output ready);
endinterface
`default_nettype wire

FILE: sv/e2q_quat_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface e2q_quat_if #(parameter int W = 16);
	logic         valid;
	logic         ready;
	logic [W-1:0] quat_w;
	logic [W-1:0] quat_x;
	logic [W-1:0] quat_y;
	logic [W-1:0] quat_z;
	modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
	modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface
`default_nettype wire

FILE: sv/euler_to_quaternion_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Handshake     Payload
// in_ch     in   valid/ready   angle_first, angle_second, angle_third (ANGLE_BITS each)
// out_ch    out  valid/ready   quat_w, quat_x, quat_y, quat_z (OUT_FRAC_BITS+2 each)
//
// One item enters per cycle while out_ch does not stall; the pipeline has 30 CORDIC rotation stages,
// two multiplier stages and the output rounding/saturation register.
// arst_n clears all valid bits; data registers are not reset.
// A stall on out_ch freezes the whole pipeline; in_ch.ready follows it.
module euler_to_quaternion_unit
	import e2q_pkg::*;
#(
	parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
	parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	e2q_angle_if.sink  in_ch,
	e2q_quat_if.source out_ch
);

	localparam int NV    = CORDIC_STEPS + 3;
	localparam int OUT_W = OUT_FRAC_BITS + 2;
	localparam int SH    = 30 - OUT_FRAC_BITS;
	localparam int SUM_W = CS_W + 2;

	logic          adv;
	logic [NV-1:0] vld_s;
	cs_t           c1, s1, c2, s2, c3, s3;

	cs_t c1c2_s1, s1s2_s1, s1c2_s1, c1s2_s1, c3_s1, s3_s1;
	cs_t wa_s2, wb_s2, xa_s2, xb_s2, ya_s2, yb_s2, za_s2, zb_s2;
	logic signed [SUM_W-1:0] w_sum, x_sum, y_sum, z_sum;
	logic signed [OUT_W-1:0] w_o, x_o, y_o, z_o;
	logic [OUT_W-1:0] w_s3, x_s3, y_s3, z_s3;

	// advance whenever the output slot is free or being taken
	assign adv         = !vld_s[NV-1] || out_ch.ready;
	assign in_ch.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NV-2:0], in_ch.valid};
		end
	end

	e2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic1 (
		.clk(clk), .en(adv), .angle(in_ch.angle_first), .cos_h(c1), .sin_h(s1));
	e2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic2 (
		.clk(clk), .en(adv), .angle(in_ch.angle_second), .cos_h(c2), .sin_h(s2));
	e2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic3 (
		.clk(clk), .en(adv), .angle(in_ch.angle_third), .cos_h(c3), .sin_h(s3));

	// pair products of the first two angles; cos and sin of the third angle are registered alongside
	always_ff @(posedge clk) begin
		if (adv) begin
			c1c2_s1 <= mul30(c1, c2);
			s1s2_s1 <= mul30(s1, s2);
			s1c2_s1 <= mul30(s1, c2);
			c1s2_s1 <= mul30(c1, s2);
			c3_s1   <= c3;
			s3_s1   <= s3;
		end
	end

	// products with the third angle
	always_ff @(posedge clk) begin
		if (adv) begin
			wa_s2 <= mul30(c1c2_s1, c3_s1);
			wb_s2 <= mul30(s1s2_s1, s3_s1);
			xa_s2 <= mul30(c1c2_s1, s3_s1);
			xb_s2 <= mul30(s1s2_s1, c3_s1);
			ya_s2 <= mul30(s1c2_s1, c3_s1);
			yb_s2 <= mul30(c1s2_s1, s3_s1);
			za_s2 <= mul30(c1s2_s1, c3_s1);
			zb_s2 <= mul30(s1c2_s1, s3_s1);
		end
	end

	assign w_sum = SUM_W'(wa_s2) - SUM_W'(wb_s2);
	assign x_sum = SUM_W'(xa_s2) + SUM_W'(xb_s2);
	assign y_sum = SUM_W'(ya_s2) + SUM_W'(yb_s2);
	assign z_sum = SUM_W'(za_s2) - SUM_W'(zb_s2);

	// round half up to the output format and clamp to plus or minus one
	function automatic logic signed [OUT_W-1:0] to_out(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] r;
		logic signed [SUM_W-1:0] one;
		one = SUM_W'(1) <<< OUT_FRAC_BITS;
		if (SH > 0) begin
			r = (v + (SUM_W'(1) <<< (SH > 0 ? SH - 1 : 0))) >>> SH;
		end else begin
			r = v;
		end
		if (r > one) begin
			r = one;
		end else if (r < -one) begin
			r = -one;
		end
		return r[OUT_W-1:0];
	endfunction

	assign w_o = to_out(w_sum);
	assign x_o = to_out(x_sum);
	assign y_o = to_out(y_sum);
	assign z_o = to_out(z_sum);

	always_ff @(posedge clk) begin
		if (adv) begin
			w_s3 <= w_o;
			x_s3 <= x_o;
			y_s3 <= y_o;
			z_s3 <= z_o;
		end
	end

	assign out_ch.valid  = vld_s[NV-1];
	assign out_ch.quat_w = w_s3;
	assign out_ch.quat_x = x_s3;
	assign out_ch.quat_y = y_s3;
	assign out_ch.quat_z = z_s3;

	// input is taken exactly when the pipeline moves
	a_ready_adv: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready == (!out_ch.valid || out_ch.ready))
		else $error("input ready does not follow pipeline advance");

	// last internal stage reaches the output on advance
	a_last_stage: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vld_s[NV-2] |=> out_ch.valid)
		else $error("result lost between last stage and output");

	// quat_w never exceeds plus or minus one
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> ($signed(out_ch.quat_w) <= $signed(OUT_W'(1) <<< OUT_FRAC_BITS))
			&& ($signed(out_ch.quat_w) >= -$signed(OUT_W'(1) <<< OUT_FRAC_BITS)))
		else $error("quat_w out of range");

endmodule
`default_nettype wire

FILE: sv/e2q_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
module e2q_cordic
	import e2q_pkg::*;
#(
	parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  en,
	input  wire logic [ANGLE_BITS-1:0] angle,
	output cs_t                        cos_h,
	output cs_t                        sin_h
);

	logic signed [ANGLE_BITS-1:0] a_sg;
	phase_t                       z_in;
	phase_t                       x_s [CORDIC_STEPS];
	phase_t                       y_s [CORDIC_STEPS];
	phase_t                       z_s [CORDIC_STEPS];

	// halve the angle and scale to 2^32 units per turn
	assign a_sg = $signed(angle);
	assign z_in = (PH_W'(a_sg) >>> 1) <<< (32 - ANGLE_BITS);

	// one rotation step per stage
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		phase_t xp, yp, zp;
		if (i == 0) begin : g_first
			assign xp = PH_W'(CORDIC_GAIN);
			assign yp = '0;
			assign zp = z_in;
		end else begin : g_next
			assign xp = x_s[i-1];
			assign yp = y_s[i-1];
			assign zp = z_s[i-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (!zp[PH_W-1]) begin
					x_s[i] <= xp - (yp >>> i);
					y_s[i] <= yp + (xp >>> i);
					z_s[i] <= zp - atan_step(i);
				end else begin
					x_s[i] <= xp + (yp >>> i);
					y_s[i] <= yp - (xp >>> i);
					z_s[i] <= zp + atan_step(i);
				end
			end
		end
	end

	assign cos_h = x_s[CORDIC_STEPS-1][CS_W-1:0];
	assign sin_h = y_s[CORDIC_STEPS-1][CS_W-1:0];

endmodule
`default_nettype wire
